// ----- hw/rtl/prc_pkg.sv -----
`default_nettype none
package prc_pkg;

	localparam int CORDIC_STEPS = 24;

	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

	localparam logic [30:0] STIFFNESS_RESET = 31'd65536;

	typedef enum logic [1:0] {
		REG_STIFFNESS = 2'd0,
		REG_OFFSET_X  = 2'd1,
		REG_OFFSET_Y  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_angle;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [47:0] residual_x;
		logic signed [47:0] residual_y;
		logic signed [47:0] force_first_x;
		logic signed [47:0] force_first_y;
		logic signed [47:0] moment_first;
		logic signed [47:0] force_second_x;
		logic signed [47:0] force_second_y;
		logic        [46:0] energy;
		logic signed [47:0] stiff_x_angle;
		logic signed [47:0] stiff_y_angle;
		logic signed [47:0] stiff_angle_angle;
	} out_beat_t;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
	} side_t;

	// one CORDIC cell's worth of state, handed down the chain
	typedef struct packed {
		logic               valid;
		logic               neg;
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		side_t              side;
	} cordic_t;

	typedef struct packed {
		logic signed [47:0] c1;
		logic signed [47:0] c2;
		logic signed [47:0] f0;
		logic signed [47:0] f1;
		logic signed [47:0] sxa;
		logic signed [47:0] sya;
	} pass_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] step);
		logic signed [33:0] r;
		unique case (step)
			5'd0:  r = 34'sd843314856;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043836;
			5'd3:  r = 34'sd133525158;
			5'd4:  r = 34'sd67021686;
			5'd5:  r = 34'sd33543515;
			5'd6:  r = 34'sd16775850;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194282;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048575;
			5'd11: r = 34'sd524287;
			5'd12: r = 34'sd262143;
			5'd13: r = 34'sd131071;
			5'd14: r = 34'sd65535;
			5'd15: r = 34'sd32767;
			5'd16: r = 34'sd16383;
			5'd17: r = 34'sd8191;
			5'd18: r = 34'sd4095;
			5'd19: r = 34'sd2047;
			5'd20: r = 34'sd1023;
			5'd21: r = 34'sd511;
			5'd22: r = 34'sd255;
			5'd23: r = 34'sd127;
			5'd24: r = 34'sd63;
			5'd25: r = 34'sd31;
			5'd26: r = 34'sd15;
			5'd27: r = 34'sd8;
			5'd28: r = 34'sd4;
			5'd29: r = 34'sd2;
			5'd30: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		logic signed [47:0] r;
		if (v > 49'(MAX48))
			r = MAX48;
		else if (v < 49'(MIN48))
			r = MIN48;
		else
			r = v[47:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/penalty_rigid_offset_constraint_unit.sv -----
// Channel | Handshake          | Beat
// in      | in_valid, in_stall | in_data  (node displacements, first node angle)
// out     | out_valid,out_stall| out_data (residuals, forces, energy, stiffness)
// cfg     | cfg_we             | cfg_index, cfg_data (no wait, no read-back)
//
// One beat per cycle in, one per cycle out, while out_stall is not holding a valid out beat.
// The angle goes through a chain of CORDIC_STEPS cells, then two layers of
// 2-stage multipliers with two sum stages between them.
// Reset clears valid bits and loads register defaults (stiffness 1.0, offset 0).
// A valid out beat held by out_stall freezes the whole pipe and stalls in in the
// same cycle; out_stall with no valid out beat has no effect.
`default_nettype none
module penalty_rigid_offset_constraint_unit import prc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_beat_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_beat_t        out_data,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [30:0]        stiffness_q;
	logic signed [31:0] ox_q, oy_q;
	logic               en;
	logic               out_valid_q;

	// advance everything unless a finished beat is held at the output
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign out_valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFFNESS_RESET;
			ox_q        <= '0;
			oy_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STIFFNESS: stiffness_q <= cfg_data[30:0];
				REG_OFFSET_X:  ox_q        <= cfg_data;
				REG_OFFSET_Y:  oy_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [47:0] k_ext;
	assign k_ext = {17'd0, stiffness_q};

	// angle reduction: take Q4.28 to Q30, drop a full turn, then a half turn
	logic signed [35:0] z0, z1, z2;
	logic               neg0;
	cordic_t            red;

	always_comb begin
		z0   = {{2{in_data.first_angle[31]}}, in_data.first_angle, 2'b00};
		z1   = z0;
		if (z0 > PI_Q30)
			z1 = z0 - TWO_PI_Q30;
		else if (z0 < -PI_Q30)
			z1 = z0 + TWO_PI_Q30;
		z2   = z1;
		neg0 = 1'b0;
		if (z1 > HALF_PI_Q30) begin
			z2   = z1 - PI_Q30;
			neg0 = 1'b1;
		end else if (z1 < -HALF_PI_Q30) begin
			z2   = z1 + PI_Q30;
			neg0 = 1'b1;
		end
		red.valid         = in_valid;
		red.neg           = neg0;
		red.x             = GAIN_Q30;
		red.y             = '0;
		red.z             = z2[33:0];
		red.side.first_x  = in_data.first_x;
		red.side.first_y  = in_data.first_y;
		red.side.second_x = in_data.second_x;
		red.side.second_y = in_data.second_y;
	end

	cordic_t link [0:CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link[0] <= '0;
		end else if (en) begin
			link[0] <= red;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		prc_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.step   (5'(i)),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	// undo the half turn and clamp to [-1, 1]
	logic signed [33:0] cx, sy;
	logic signed [31:0] cos_v, sin_v;
	always_comb begin
		cx = link[CORDIC_STEPS].neg ? -link[CORDIC_STEPS].x : link[CORDIC_STEPS].x;
		sy = link[CORDIC_STEPS].neg ? -link[CORDIC_STEPS].y : link[CORDIC_STEPS].y;
		if (cx > ONE_Q30)
			cos_v = 32'(ONE_Q30);
		else if (cx < -ONE_Q30)
			cos_v = 32'(-ONE_Q30);
		else
			cos_v = cx[31:0];
		if (sy > ONE_Q30)
			sin_v = 32'(ONE_Q30);
		else if (sy < -ONE_Q30)
			sin_v = 32'(-ONE_Q30);
		else
			sin_v = sy[31:0];
	end

	logic               valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic               valid_s7, valid_s8, valid_s9, valid_s10;
	logic signed [31:0] cos_s2, sin_s2;
	side_t              side_s2, side_s3;
	logic signed [63:0] oxc_s3, oys_s3, oxs_s3, oyc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s2  <= link[CORDIC_STEPS].valid;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// rotation products, one multiplier per lane
	always_ff @(posedge clk) begin
		if (en) begin
			cos_s2  <= cos_v;
			sin_s2  <= sin_v;
			side_s2 <= link[CORDIC_STEPS].side;
			oxc_s3  <= ox_q * cos_s2;
			oys_s3  <= oy_q * sin_s2;
			oxs_s3  <= ox_q * sin_s2;
			oyc_s3  <= oy_q * cos_s2;
			side_s3 <= side_s2;
		end
	end

	// rotated offset back to Q16.16 (round half up), then residuals
	logic signed [65:0] rx_full, ry_full;
	logic signed [35:0] rx_v, ry_v;
	logic signed [36:0] c1_v, c2_v;
	logic signed [47:0] rx_s4, ry_s4, c1_s4, c2_s4, mry_s4;

	always_comb begin
		rx_full = 66'(oxc_s3) - 66'(oys_s3) + 66'sd536870912;
		ry_full = 66'(oxs_s3) + 66'(oyc_s3) + 66'sd536870912;
		rx_v    = rx_full[65:30];
		ry_v    = ry_full[65:30];
		c1_v    = 37'(rx_v) + 37'(side_s3.first_x) - 37'(side_s3.second_x);
		c2_v    = 37'(ry_v) + 37'(side_s3.first_y) - 37'(side_s3.second_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s4  <= 48'(rx_v);
			ry_s4  <= 48'(ry_v);
			mry_s4 <= 48'(-ry_v);
			c1_s4  <= 48'(c1_v);
			c2_s4  <= 48'(c2_v);
		end
	end

	// first multiplier layer, results at s6
	logic signed [47:0] kc1, kc2, c2rx, c1ry, rxrx, ryry, c1rx, c2ry, c1c1, c2c2, kmry, krx;

	prc_mul u_kc1  (.clk(clk), .en(en), .a(k_ext), .b(c1_s4),  .sh17(1'b0), .prod(kc1));
	prc_mul u_kc2  (.clk(clk), .en(en), .a(k_ext), .b(c2_s4),  .sh17(1'b0), .prod(kc2));
	prc_mul u_c2rx (.clk(clk), .en(en), .a(c2_s4), .b(rx_s4),  .sh17(1'b0), .prod(c2rx));
	prc_mul u_c1ry (.clk(clk), .en(en), .a(c1_s4), .b(ry_s4),  .sh17(1'b0), .prod(c1ry));
	prc_mul u_rxrx (.clk(clk), .en(en), .a(rx_s4), .b(rx_s4),  .sh17(1'b0), .prod(rxrx));
	prc_mul u_ryry (.clk(clk), .en(en), .a(ry_s4), .b(ry_s4),  .sh17(1'b0), .prod(ryry));
	prc_mul u_c1rx (.clk(clk), .en(en), .a(c1_s4), .b(rx_s4),  .sh17(1'b0), .prod(c1rx));
	prc_mul u_c2ry (.clk(clk), .en(en), .a(c2_s4), .b(ry_s4),  .sh17(1'b0), .prod(c2ry));
	prc_mul u_c1c1 (.clk(clk), .en(en), .a(c1_s4), .b(c1_s4),  .sh17(1'b0), .prod(c1c1));
	prc_mul u_c2c2 (.clk(clk), .en(en), .a(c2_s4), .b(c2_s4),  .sh17(1'b0), .prod(c2c2));
	prc_mul u_kmry (.clk(clk), .en(en), .a(k_ext), .b(mry_s4), .sh17(1'b0), .prod(kmry));
	prc_mul u_krx  (.clk(clk), .en(en), .a(k_ext), .b(rx_s4),  .sh17(1'b0), .prod(krx));

	logic signed [47:0] c1_s5, c2_s5, c1_s6, c2_s6;
	pass_t              pass_s7, pass_s8, pass_s9, pass_s10;
	logic signed [47:0] p_s7, g_s7, h_s7, q_s7;
	logic signed [47:0] p_s8, t_s8, q_s8;

	// sums of the first layer, then tangent term; carry the rest alongside
	always_ff @(posedge clk) begin
		if (en) begin
			c1_s5       <= c1_s4;
			c2_s5       <= c2_s4;
			c1_s6       <= c1_s5;
			c2_s6       <= c2_s5;
			pass_s7.c1  <= c1_s6;
			pass_s7.c2  <= c2_s6;
			pass_s7.f0  <= kc1;
			pass_s7.f1  <= kc2;
			pass_s7.sxa <= kmry;
			pass_s7.sya <= krx;
			p_s7        <= sat48(49'(c2rx) - 49'(c1ry));
			g_s7        <= sat48(49'(rxrx) + 49'(ryry));
			h_s7        <= sat48(49'(c1rx) + 49'(c2ry));
			q_s7        <= sat48(49'(c1c1) + 49'(c2c2));
			pass_s8     <= pass_s7;
			p_s8        <= p_s7;
			t_s8        <= sat48(49'(g_s7) - 49'(h_s7));
			q_s8        <= q_s7;
			pass_s9     <= pass_s8;
			pass_s10    <= pass_s9;
		end
	end

	// second multiplier layer, results at s10
	logic signed [47:0] kp, kt, kq;

	prc_mul u_kp (.clk(clk), .en(en), .a(k_ext), .b(p_s8), .sh17(1'b0), .prod(kp));
	prc_mul u_kt (.clk(clk), .en(en), .a(k_ext), .b(t_s8), .sh17(1'b0), .prod(kt));
	prc_mul u_kq (.clk(clk), .en(en), .a(k_ext), .b(q_s8), .sh17(1'b1), .prod(kq));

	// output register: saturated negations and energy floor
	out_beat_t res;
	always_comb begin
		res.residual_x        = pass_s10.c1;
		res.residual_y        = pass_s10.c2;
		res.force_first_x     = pass_s10.f0;
		res.force_first_y     = pass_s10.f1;
		res.moment_first      = kp;
		res.force_second_x    = (pass_s10.f0 == MIN48) ? MAX48 : -pass_s10.f0;
		res.force_second_y    = (pass_s10.f1 == MIN48) ? MAX48 : -pass_s10.f1;
		res.energy            = kq[47] ? 47'd0 : kq[46:0];
		res.stiff_x_angle     = pass_s10.sxa;
		res.stiff_y_angle     = pass_s10.sya;
		res.stiff_angle_angle = kt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= res;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/prc_cordic_cell.sv -----
`default_nettype none
module prc_cordic_cell import prc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic [4:0] step,
	input  wire cordic_t    din,
	output cordic_t         dout
);

	logic signed [33:0] xs, ys, at;
	cordic_t            nxt;

	always_comb begin
		xs  = din.x >>> step;
		ys  = din.y >>> step;
		at  = atan_q30(step);
		nxt = din;
		// rotate toward zero residual angle
		if (!din.z[33]) begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - at;
		end else begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/prc_mul.sv -----
`default_nettype none
module prc_mul import prc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [47:0] a,
	input  wire logic signed [47:0] b,
	input  wire logic               sh17,
	output logic signed [47:0]      prod
);

	logic [47:0] mag_a, mag_b;
	logic [47:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic        neg_s1, sh17_s1;
	logic [48:0] mid;
	logic [96:0] full, rnd, rsum, mag;
	logic signed [47:0] res;

	assign mag_a = a[47] ? 48'(-a) : 48'(a);
	assign mag_b = b[47] ? 48'(-b) : 48'(b);

	// four 24x24 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= 48'(mag_a[23:0] * mag_b[23:0]);
			lh_s1   <= 48'(mag_a[23:0] * mag_b[47:24]);
			hl_s1   <= 48'(mag_a[47:24] * mag_b[23:0]);
			hh_s1   <= 48'(mag_a[47:24] * mag_b[47:24]);
			neg_s1  <= a[47] ^ b[47];
			sh17_s1 <= sh17;
		end
	end

	always_comb begin
		mid  = {1'b0, lh_s1} + {1'b0, hl_s1};
		full = {1'b0, hh_s1, 48'd0} + {24'd0, mid, 24'd0} + {49'd0, ll_s1};
		rnd  = sh17_s1 ? (97'd1 << 16) : (97'd1 << 15);
		rsum = full + rnd;
		mag  = sh17_s1 ? (rsum >> 17) : (rsum >> 16);
		if (neg_s1) begin
			if (mag > 97'h8000_0000_0000)
				res = MIN48;
			else
				res = 48'(-mag[47:0]);
		end else begin
			if (mag > 97'h7FFF_FFFF_FFFF)
				res = MAX48;
			else
				res = mag[47:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= res;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/prc_checker.sv -----
`default_nettype none
module prc_checker import prc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire in_beat_t    in_data,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire out_beat_t   out_data
);

	// hold a stalled input beat
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("in beat changed under stall");

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out beat dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("out beat changed under stall");

	// a blocked output freezes the pipe and so the input side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while pipe frozen");

	// second node x force is the saturated negation of the first node x force
	a_force_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.force_second_x ==
			((out_data.force_first_x == MIN48) ? MAX48 : -out_data.force_first_x)))
		else $error("force pair mismatch");

endmodule

bind penalty_rigid_offset_constraint_unit prc_checker u_prc_checker (.*);
`default_nettype wire
